>>> design/hwfr_pkg.sv
`timescale 1ns / 1ps
// hwfr_pkg: codes, constants and reset values of the heat warning block
// no dependencies
package hwfr_pkg;

  // operation codes of an input item
  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_SAMPLE   = 3'd1,
    OP_ACTIVATE = 3'd2,
    OP_RESET    = 3'd3,
    OP_UNKNOWN  = 3'd4
  } op_t;

  // shown state
  typedef enum logic [1:0] {
    DISP_NORMAL  = 2'd0,
    DISP_WARNING = 2'd1,
    DISP_FIRE    = 2'd2,
    DISP_ERROR   = 2'd3
  } disp_t;

  // command answer
  typedef enum logic [1:0] {
    ACK_NONE   = 2'd0,
    ACK_DONE   = 2'd1,
    ACK_REJECT = 2'd2
  } ack_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_WARN_TEMP  = 2'd0,
    CFG_WARN_DELTA = 2'd1,
    CFG_WARN_RISE  = 2'd2,
    CFG_PUMP_DELAY = 2'd3
  } cfg_idx_t;

  localparam int CFG_IDX_W = 2;

  // valid temperature window, exclusive, hundredths of a degree
  localparam logic signed [15:0] TEMP_LOW  = -16'sd5000;
  localparam logic signed [15:0] TEMP_HIGH = 16'sd20000;

  localparam int MS_PER_MIN = 60000;

  // register reset values
  localparam logic signed [15:0] WARN_TEMP_RST  = 16'sd3500;
  localparam logic signed [15:0] WARN_DELTA_RST = 16'sd800;
  localparam logic signed [15:0] WARN_RISE_RST  = 16'sd800;
  localparam logic [31:0]        PUMP_DELAY_RST = 32'd5000;

endpackage

>>> design/hwfr_if.sv
`timescale 1ns / 1ps
// channel interfaces of the heat warning block: input items, results, config writes
// no dependencies
interface hwfr_item_if;
  logic               valid;
  logic               ready;
  logic [2:0]         operation;
  logic [31:0]        now_ms;
  logic signed [15:0] indoor_temp;
  logic               indoor_ok;
  logic signed [15:0] outdoor_temp;
  logic               outdoor_ok;

  modport source (output valid, operation, now_ms, indoor_temp, indoor_ok,
                  outdoor_temp, outdoor_ok, input ready);
  modport sink (input valid, operation, now_ms, indoor_temp, indoor_ok,
                outdoor_temp, outdoor_ok, output ready);
endinterface

interface hwfr_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] display_state;
  logic       emergency_on;
  logic       barrier_on;
  logic       pump_on;
  logic [1:0] ack;
  logic       hot_flag;
  logic       delta_flag;
  logic       rise_flag;

  modport source (output valid, display_state, emergency_on, barrier_on, pump_on,
                  ack, hot_flag, delta_flag, rise_flag, input ready);
  modport sink (input valid, display_state, emergency_on, barrier_on, pump_on,
                ack, hot_flag, delta_flag, rise_flag, output ready);
endinterface

interface hwfr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  addr;
  logic [31:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

>>> design/heat_warning_and_fire_response.sv
`timescale 1ns / 1ps
// heat_warning_and_fire_response: heat warning checks and fire response sequencing
// depends on hwfr_pkg and the channel interfaces in hwfr_if.sv
//
//   channel   dir   handshake     payload
//   items     in    valid/ready   operation, now_ms, indoor/outdoor temp and ok bits
//   results   out   valid/ready   display_state, relays, ack, rule flags
//   cfg       in    valid/ready   addr (register index), data
//
// one transaction in, one transaction out, one item per cycle sustained while results.ready stays high
// items pass through the input register, then the checks (compare and one
// 17x16 and one 16x33 multiply for the rise rule) feed the result register
// rst is synchronous and active high, it restores the config and state register defaults
// a stalled result holds in the result register while the input register
// still takes one more item; items.ready drops only when both are full
module heat_warning_and_fire_response (
  input logic           clk,
  input logic           rst,
  hwfr_item_if.sink     items,
  hwfr_result_if.source results,
  hwfr_cfg_if.sink      cfg
);
  import hwfr_pkg::*;

  // result of one item
  typedef struct packed {
    disp_t disp;
    logic  em;
    logic  pump;
    ack_t  ack;
    logic  hot;
    logic  dlt;
    logic  rise;
  } res_t;

  // configuration registers
  logic signed [15:0] warn_temp;
  logic signed [15:0] warn_delta;
  logic signed [15:0] warn_rise;
  logic [31:0]        pump_delay;

  // controller state
  logic               emergency;
  logic               pump;
  logic [31:0]        barrier_time;
  logic signed [15:0] last_temp;
  logic               last_temp_valid;
  logic [31:0]        last_time;
  disp_t              shown_state;

  // input register
  logic               s1_valid;
  logic [2:0]         s1_op;
  logic [31:0]        s1_now;
  logic signed [15:0] s1_tin;
  logic               s1_tin_ok;
  logic signed [15:0] s1_tout;
  logic               s1_tout_ok;
  logic               s1_advance;

  // result register
  logic res_valid;
  res_t res;

  // next values
  logic               emergency_next;
  logic               pump_next;
  logic [31:0]        barrier_time_next;
  logic signed [15:0] last_temp_next;
  logic               last_temp_valid_next;
  logic [31:0]        last_time_next;
  disp_t              shown_state_next;
  res_t               res_next;

  // checks
  op_t                op;
  logic               in_ok;
  logic               out_ok;
  logic               hot;
  logic               dlt;
  logic               rise;
  logic signed [16:0] diff_io;
  logic signed [16:0] diff_last;
  logic [31:0]        elapsed;
  logic signed [48:0] rise_lhs;
  logic signed [48:0] rise_rhs;
  logic [31:0]        since_barrier;

  // configuration port, always ready
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      warn_temp  <= WARN_TEMP_RST;
      warn_delta <= WARN_DELTA_RST;
      warn_rise  <= WARN_RISE_RST;
      pump_delay <= PUMP_DELAY_RST;
    end else if (cfg.valid) begin
      unique case (cfg_idx_t'(cfg.addr))
        CFG_WARN_TEMP:  warn_temp  <= $signed(cfg.data[15:0]);
        CFG_WARN_DELTA: warn_delta <= $signed(cfg.data[15:0]);
        CFG_WARN_RISE:  warn_rise  <= $signed(cfg.data[15:0]);
        CFG_PUMP_DELAY: pump_delay <= cfg.data;
        default: ;
      endcase
    end
  end

  // handshake: the input register moves on when the result register is free
  assign s1_advance  = s1_valid && (!res_valid || results.ready);
  assign items.ready = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (items.ready) begin
      s1_valid <= items.valid;
    end
  end

  // payload of the input register, no reset needed
  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      s1_op      <= items.operation;
      s1_now     <= items.now_ms;
      s1_tin     <= items.indoor_temp;
      s1_tin_ok  <= items.indoor_ok;
      s1_tout    <= items.outdoor_temp;
      s1_tout_ok <= items.outdoor_ok;
    end
  end

  // sensor validity: ok bit and strictly inside the window
  assign in_ok  = s1_tin_ok && (s1_tin > TEMP_LOW) && (s1_tin < TEMP_HIGH);
  assign out_ok = s1_tout_ok && (s1_tout > TEMP_LOW) && (s1_tout < TEMP_HIGH);

  // absolute level and inside minus outside rules
  assign diff_io = {s1_tin[15], s1_tin} - {s1_tout[15], s1_tout};
  assign hot     = in_ok && (s1_tin >= warn_temp);
  assign dlt     = in_ok && out_ok && (diff_io >= $signed({warn_delta[15], warn_delta}));

  // rise rule: (tin - last) * 60000 >= warn_rise * elapsed, no division
  assign diff_last = {s1_tin[15], s1_tin} - {last_temp[15], last_temp};
  assign elapsed   = s1_now - last_time;
  assign rise_lhs  = $signed({{32{diff_last[16]}}, diff_last}) * $signed(49'(MS_PER_MIN));
  assign rise_rhs  = $signed({{33{warn_rise[15]}}, warn_rise}) * $signed({17'd0, elapsed});
  assign rise      = in_ok && last_temp_valid && (elapsed != 32'd0) && (rise_lhs >= rise_rhs);

  assign op = op_t'(s1_op);

  always_comb begin
    emergency_next       = emergency;
    pump_next            = pump;
    barrier_time_next    = barrier_time;
    last_temp_next       = last_temp;
    last_temp_valid_next = last_temp_valid;
    last_time_next       = last_time;
    shown_state_next     = shown_state;
    res_next             = '0;
    res_next.ack         = ACK_NONE;
    unique case (op)
      OP_TICK: ;
      OP_SAMPLE: begin
        res_next.hot  = hot;
        res_next.dlt  = dlt;
        res_next.rise = rise;
        // fire overrides a sensor error, which overrides the rules
        if (emergency) begin
          shown_state_next = DISP_FIRE;
        end else if (!in_ok) begin
          shown_state_next = DISP_ERROR;
        end else if (hot || dlt || rise) begin
          shown_state_next = DISP_WARNING;
        end else begin
          shown_state_next = DISP_NORMAL;
        end
        if (in_ok) begin
          last_temp_next       = s1_tin;
          last_temp_valid_next = 1'b1;
          last_time_next       = s1_now;
        end
      end
      OP_ACTIVATE: begin
        // a repeated activate leaves the running response alone
        if (!emergency) begin
          emergency_next    = 1'b1;
          pump_next         = 1'b0;
          shown_state_next  = DISP_FIRE;
          barrier_time_next = s1_now;
        end
        res_next.ack = ACK_DONE;
      end
      OP_RESET: begin
        emergency_next   = 1'b0;
        pump_next        = 1'b0;
        shown_state_next = DISP_NORMAL;
        res_next.ack     = ACK_DONE;
      end
      default: res_next.ack = ACK_REJECT;
    endcase

    // pump starts once the delay since barrier activation has run out
    since_barrier = s1_now - barrier_time_next;
    if (emergency_next && !pump_next && (since_barrier >= pump_delay)) begin
      pump_next = 1'b1;
    end

    res_next.disp = shown_state_next;
    res_next.em   = emergency_next;
    res_next.pump = pump_next;
  end

  // state commits when the item moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      emergency       <= 1'b0;
      pump            <= 1'b0;
      barrier_time    <= '0;
      last_temp       <= '0;
      last_temp_valid <= 1'b0;
      last_time       <= '0;
      shown_state     <= DISP_NORMAL;
      res_valid       <= 1'b0;
    end else begin
      if (s1_advance) begin
        emergency       <= emergency_next;
        pump            <= pump_next;
        barrier_time    <= barrier_time_next;
        last_temp       <= last_temp_next;
        last_temp_valid <= last_temp_valid_next;
        last_time       <= last_time_next;
        shown_state     <= shown_state_next;
        res_valid       <= 1'b1;
      end else if (results.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      res <= res_next;
    end
  end

  // result channel, barrier relay follows the emergency
  assign results.valid         = res_valid;
  assign results.display_state = res.disp;
  assign results.emergency_on  = res.em;
  assign results.barrier_on    = res.em;
  assign results.pump_on       = res.pump;
  assign results.ack           = res.ack;
  assign results.hot_flag      = res.hot;
  assign results.delta_flag    = res.dlt;
  assign results.rise_flag     = res.rise;

`ifndef SYNTHESIS
  // the pump never runs without an active emergency
  a_pump_needs_emergency: assert property (@(posedge clk) disable iff (rst)
    pump |-> emergency)
    else $error("pump on without emergency");

  // a command answer never comes with rule flags
  a_flags_only_on_samples: assert property (@(posedge clk) disable iff (rst)
    (results.valid && (results.ack != ACK_NONE)) |->
      !(results.hot_flag || results.delta_flag || results.rise_flag))
    else $error("rule flag set on a command");

  // an emergency is always shown as fire
  a_emergency_shows_fire: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.emergency_on) |-> (results.display_state == DISP_FIRE))
    else $error("emergency not shown as fire");

  // a blocked item stays in the input register
  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_advance) |=> (s1_valid && $stable(s1_now) && $stable(s1_op)))
    else $error("input register lost a stalled item");
`endif

endmodule
